### src/imot_pkg.sv
`default_nettype none

package imot_pkg;

  // Sizes
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ORIENT_W       = 5;
  localparam int NUM_SLOTS      = 24;
  localparam int NUM_COMP       = 4;
  localparam int NUM_STAGES     = 5;

  // Command codes carried in tuser
  localparam logic CMD_VECTOR = 1'b0;
  localparam logic CMD_QUAT   = 1'b1;

  // Quaternion coefficient magnitudes
  localparam logic [1:0] COEF_ZERO = 2'd0;
  localparam logic [1:0] COEF_ONE  = 2'd1;
  localparam logic [1:0] COEF_HALF = 2'd2;
  localparam logic [1:0] COEF_SQH  = 2'd3;

  // sqrt(1/2) as a 0.32 fraction and the rounding bias for the >> 32
  localparam int         SQH_W         = 32;
  localparam logic [31:0] SQRT_HALF_Q32 = 32'd3037000500;
  localparam logic [31:0] RND_HALF      = 32'h8000_0000;

  // Row i of the rotation reads column perm[i]; packed {perm2, perm1, perm0}
  localparam logic [5:0] SLOT_PERM [NUM_SLOTS] = '{
    6'h24, 6'h21, 6'h24, 6'h21,
    6'h24, 6'h24, 6'h18, 6'h18, 6'h18, 6'h18, 6'h21, 6'h21,
    6'h09, 6'h09, 6'h09, 6'h09, 6'h12, 6'h12, 6'h12, 6'h12,
    6'h06, 6'h06, 6'h06, 6'h06
  };

  // Row sign, set bit means -1; packed {neg2, neg1, neg0}
  localparam logic [2:0] SLOT_NEG [NUM_SLOTS] = '{
    3'b000, 3'b001, 3'b011, 3'b010,
    3'b101, 3'b110, 3'b111, 3'b001, 3'b010, 3'b100, 3'b111, 3'b100,
    3'b011, 3'b101, 3'b110, 3'b000, 3'b011, 3'b101, 3'b110, 3'b000,
    3'b111, 3'b001, 3'b010, 3'b100
  };

  // Hamilton product: output k, term t uses p[t] times r[HAM_R[k][t]]
  localparam logic [1:0] HAM_R [NUM_COMP][NUM_COMP] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // Term carries an extra minus sign
  localparam logic HAM_M [NUM_COMP][NUM_COMP] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  // Decoded mounting rotation
  typedef struct packed {
    logic [2:0][1:0] perm;
    logic [2:0]      vneg;
    logic [3:0][1:0] qcode;
    logic [3:0]      qneg;
  } slot_ctrl_t;

  // Control that travels with each transaction
  typedef struct packed {
    logic       cmd;
    slot_ctrl_t slot;
  } stage_ctrl_t;

  // Coefficient code for n / (2*sqrt(d)), d in {1,2,4}
  function automatic logic [1:0] side_code(input int n, input int d);
    int         a;
    logic [1:0] c;
    a = (n < 0) ? -n : n;
    c = COEF_ZERO;
    if (a != 0) begin
      if (d == 4) begin
        c = (a == 2) ? COEF_HALF : COEF_ZERO;
      end else if (d == 2) begin
        c = (a == 2) ? COEF_SQH : COEF_ZERO;
      end else if (d == 1) begin
        c = (a == 1) ? COEF_HALF : ((a == 2) ? COEF_ONE : COEF_ZERO);
      end
    end
    return c;
  endfunction

  // Matrix and conjugated unit quaternion for one orientation register value
  function automatic slot_ctrl_t slot_decode(input logic [ORIENT_W-1:0] orient);
    slot_ctrl_t          c;
    logic [ORIENT_W-1:0] s;
    int                  m [3][3];
    int                  n [4];
    int                  tr;
    int                  d;
    int                  mi;
    s = (orient < ORIENT_W'(NUM_SLOTS)) ? orient : '0;
    c = '0;
    c.perm = SLOT_PERM[s];
    c.vneg = SLOT_NEG[s];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = (int'(c.perm[i]) == j) ? (c.vneg[i] ? -1 : 1) : 0;
      end
    end
    n[0] = 0; n[1] = 0; n[2] = 0; n[3] = 0;
    tr = m[0][0] + m[1][1] + m[2][2];
    // Trace branch, else the largest diagonal entry
    if (tr > 0) begin
      mi = 0; d = tr + 1;
      n[1] = m[2][1] - m[1][2]; n[2] = m[0][2] - m[2][0]; n[3] = m[1][0] - m[0][1];
    end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
      mi = 1; d = 1 + m[0][0] - m[1][1] - m[2][2];
      n[0] = m[2][1] - m[1][2]; n[2] = m[0][1] + m[1][0]; n[3] = m[0][2] + m[2][0];
    end else if (m[1][1] > m[2][2]) begin
      mi = 2; d = 1 + m[1][1] - m[0][0] - m[2][2];
      n[0] = m[0][2] - m[2][0]; n[1] = m[0][1] + m[1][0]; n[3] = m[1][2] + m[2][1];
    end else begin
      mi = 3; d = 1 + m[2][2] - m[0][0] - m[1][1];
      n[0] = m[1][0] - m[0][1]; n[1] = m[0][2] + m[2][0]; n[2] = m[1][2] + m[2][1];
    end
    for (int k = 0; k < 4; k++) begin
      if (k == mi) begin
        c.qcode[k] = (d == 4) ? COEF_ONE : ((d == 2) ? COEF_SQH : COEF_HALF);
        c.qneg[k]  = 1'b0;
      end else begin
        c.qcode[k] = side_code(n[k], d);
        c.qneg[k]  = (n[k] < 0);
      end
    end
    // Conjugate: flip the vector part
    c.qneg[3:1] = ~c.qneg[3:1];
    return c;
  endfunction

endpackage

`default_nettype wire

### src/imot_cfg.sv
`default_nettype none

module imot_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [imot_pkg::ORIENT_W-1:0] cfg_wr_data,
  output imot_pkg::slot_ctrl_t               slot_o
);

  imot_pkg::slot_ctrl_t slot_r;

  // Decode on write so the next transaction sees the new rotation at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= imot_pkg::slot_decode('0);
    end else if (cfg_wr_en) begin
      slot_r <= imot_pkg::slot_decode(cfg_wr_data);
    end
  end

  assign slot_o = slot_r;

endmodule

`default_nettype wire

### src/imot_scale.sv
`default_nettype none

module imot_scale #(
  parameter int DATA_WIDTH = imot_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en_mul,
  input  wire logic                  en_rnd,
  input  wire logic [DATA_WIDTH-1:0] mag_i,
  input  wire logic                  neg_i,
  output logic      [DATA_WIDTH-1:0] mag_o,
  output logic      [DATA_WIDTH-1:0] half_o,
  output logic      [DATA_WIDTH-1:0] sqh_o,
  output logic                       neg_o
);

  localparam int KW   = imot_pkg::SQH_W;
  localparam int LO_W = (DATA_WIDTH > KW) ? KW : DATA_WIDTH;
  localparam int HI_W = (DATA_WIDTH > KW) ? DATA_WIDTH - KW : 1;
  localparam int SW   = HI_W + KW + 1;

  logic [LO_W-1:0]       mag_lo;
  logic [HI_W-1:0]       mag_hi;
  logic [LO_W+KW-1:0]    lo_prod_nxt;
  logic [LO_W+KW-1:0]    lo_prod_r;
  logic [HI_W+KW-1:0]    hi_prod_nxt;
  logic [HI_W+KW-1:0]    hi_prod_r;
  logic [DATA_WIDTH:0]   inc;
  logic [DATA_WIDTH-1:0] half_nxt;
  logic [DATA_WIDTH-1:0] half2_r;
  logic [DATA_WIDTH-1:0] mag2_r;
  logic                  neg2_r;
  logic [LO_W+KW:0]      lo_rnd;
  logic [SW-1:0]         sqh_sum;
  logic [DATA_WIDTH-1:0] mag3_r;
  logic [DATA_WIDTH-1:0] half3_r;
  logic [DATA_WIDTH-1:0] sqh3_r;
  logic                  neg3_r;

  // Split the magnitude at bit 32 for the two partial products
  assign mag_lo = mag_i[LO_W-1:0];
  if (DATA_WIDTH > KW) begin : g_wide
    assign mag_hi = mag_i[DATA_WIDTH-1:LO_W];
  end else begin : g_narrow
    assign mag_hi = '0;
  end

  assign lo_prod_nxt = (LO_W+KW)'(mag_lo) * (LO_W+KW)'(imot_pkg::SQRT_HALF_Q32);
  assign hi_prod_nxt = (HI_W+KW)'(mag_hi) * (HI_W+KW)'(imot_pkg::SQRT_HALF_Q32);

  // Half with round away from zero on the magnitude
  assign inc      = {1'b0, mag_i} + (DATA_WIDTH+1)'(1);
  assign half_nxt = inc[DATA_WIDTH:1];

  // Multiply stage
  always_ff @(posedge clk) begin
    if (en_mul) begin
      lo_prod_r <= lo_prod_nxt;
      hi_prod_r <= hi_prod_nxt;
      half2_r   <= half_nxt;
      mag2_r    <= mag_i;
      neg2_r    <= neg_i;
    end
  end

  // Round the low product and add in the high one
  assign lo_rnd  = {1'b0, lo_prod_r} + (LO_W+KW+1)'(imot_pkg::RND_HALF);
  assign sqh_sum = SW'(hi_prod_r) + SW'(lo_rnd[LO_W+KW:KW]);

  always_ff @(posedge clk) begin
    if (en_rnd) begin
      mag3_r  <= mag2_r;
      half3_r <= half2_r;
      sqh3_r  <= sqh_sum[DATA_WIDTH-1:0];
      neg3_r  <= neg2_r;
    end
  end

  assign mag_o  = mag3_r;
  assign half_o = half3_r;
  assign sqh_o  = sqh3_r;
  assign neg_o  = neg3_r;

endmodule

`default_nettype wire

### src/imot_combine.sv
`default_nettype none

module imot_combine #(
  parameter int DATA_WIDTH = imot_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      en_term,
  input  wire logic                                      en_sum,
  input  wire imot_pkg::stage_ctrl_t                     ctrl,
  input  wire logic [imot_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] mag,
  input  wire logic [imot_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] half,
  input  wire logic [imot_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] sqh,
  input  wire logic [imot_pkg::NUM_COMP-1:0]                 neg,
  output logic      [imot_pkg::NUM_COMP-1:0][DATA_WIDTH-1:0] res
);

  localparam int NC = imot_pkg::NUM_COMP;
  localparam int TW = DATA_WIDTH + 1;
  localparam int SW = DATA_WIDTH + 3;
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [TW-1:0]   term_nxt [NC][NC];
  logic signed [TW-1:0]   term_r   [NC][NC];
  logic [DATA_WIDTH-1:0]  val;
  logic                   sgn;
  logic [1:0]             src;
  logic signed [SW-1:0]   sum      [NC];
  logic [NC-1:0][DATA_WIDTH-1:0] sat;
  logic [NC-1:0][DATA_WIDTH-1:0] res_r;

  // Scaled magnitude for one coefficient code
  function automatic logic [DATA_WIDTH-1:0] pick(
    input logic [1:0]            code,
    input logic [DATA_WIDTH-1:0] m,
    input logic [DATA_WIDTH-1:0] h,
    input logic [DATA_WIDTH-1:0] q
  );
    logic [DATA_WIDTH-1:0] r;
    case (code)
      imot_pkg::COEF_ONE:  r = m;
      imot_pkg::COEF_HALF: r = h;
      imot_pkg::COEF_SQH:  r = q;
      default:             r = '0;
    endcase
    return r;
  endfunction

  // Form signed terms: the Hamilton product or one remapped axis
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      for (int t = 0; t < NC; t++) begin
        val = '0;
        sgn = 1'b0;
        src = '0;
        if (ctrl.cmd == imot_pkg::CMD_QUAT) begin
          src = imot_pkg::HAM_R[k][t];
          val = pick(ctrl.slot.qcode[src], mag[t], half[t], sqh[t]);
          sgn = neg[t] ^ ctrl.slot.qneg[src] ^ imot_pkg::HAM_M[k][t];
        end else if (k != 0 && t == 0) begin
          src = ctrl.slot.perm[k-1] + 2'd1;
          val = mag[src];
          sgn = neg[src] ^ ctrl.slot.vneg[k-1];
        end
        term_nxt[k][t] = sgn ? -$signed({1'b0, val}) : $signed({1'b0, val});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_term) begin
      term_r <= term_nxt;
    end
  end

  // Add the four terms and saturate
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sum[k] = SW'(term_r[k][0]) + SW'(term_r[k][1]) + SW'(term_r[k][2]) + SW'(term_r[k][3]);
      if (sum[k][SW-1:DATA_WIDTH-1] == '0 || sum[k][SW-1:DATA_WIDTH-1] == '1) begin
        sat[k] = sum[k][DATA_WIDTH-1:0];
      end else begin
        sat[k] = sum[k][SW-1] ? MIN_NEG : MAX_POS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      res_r <= sat;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

### src/imu_mount_orientation_transform_top.sv
// IMU mount remap: turns sensor vectors (tuser 0) or Q2.30 quaternions (tuser 1) into the
// boat frame for one of 24 axis-aligned mountings chosen by a 5-bit register (values 24-31
// act as the identity). Vector results are the signed, permuted axes with out_w zero;
// quaternion results are p * conj(q) with q the mounting's unit quaternion, products by 1/2
// and sqrt(1/2) rounded to nearest and sums saturated. The pipeline takes one transaction
// per clock while in_tready is high and runs it through five stages; the sqrt(1/2)
// multiply spans two of them. in_tready drops only when all stages are full and out_tready
// is low. A register write takes effect for the next accepted transaction.
`default_nettype none

module imu_mount_orientation_transform_top #(
  parameter int DATA_WIDTH = imot_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [imot_pkg::ORIENT_W-1:0] cfg_wr_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [4*DATA_WIDTH-1:0]       in_tdata,   // in_w, in_x, in_y, in_z
  input  wire logic                          in_tuser,   // cmd
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [4*DATA_WIDTH-1:0]       out_tdata   // out_w, out_x, out_y, out_z
);

  localparam int NC = imot_pkg::NUM_COMP;
  localparam int NS = imot_pkg::NUM_STAGES;

  imot_pkg::slot_ctrl_t  slot;
  imot_pkg::stage_ctrl_t ctrl_r [3];
  logic [NS-1:0]         vld_r;
  logic [NS-1:0]         en;
  logic [NC-1:0][DATA_WIDTH-1:0] raw;
  logic [NC-1:0][DATA_WIDTH-1:0] mag1_r;
  logic [NC-1:0]                 neg1_r;
  logic [NC-1:0][DATA_WIDTH-1:0] mag3;
  logic [NC-1:0][DATA_WIDTH-1:0] half3;
  logic [NC-1:0][DATA_WIDTH-1:0] sqh3;
  logic [NC-1:0]                 neg3;
  logic [NC-1:0][DATA_WIDTH-1:0] res;

  imot_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .slot_o      (slot)
  );

  // A stage advances when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Carry command and decoded rotation along with the data
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ctrl_r[0] <= '{cmd: in_tuser, slot: slot};
    end
    if (en[1]) begin
      ctrl_r[1] <= ctrl_r[0];
    end
    if (en[2]) begin
      ctrl_r[2] <= ctrl_r[1];
    end
  end

  // Stage 1: split each component into sign and magnitude
  assign raw = in_tdata;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NC; k++) begin
        neg1_r[k] <= raw[k][DATA_WIDTH-1];
        mag1_r[k] <= raw[k][DATA_WIDTH-1] ? ('0 - raw[k]) : raw[k];
      end
    end
  end

  // Stages 2 and 3: constant products per component
  for (genvar g = 0; g < NC; g++) begin : g_scale
    imot_scale #(.DATA_WIDTH(DATA_WIDTH)) u_scale (
      .clk    (clk),
      .en_mul (en[1]),
      .en_rnd (en[2]),
      .mag_i  (mag1_r[g]),
      .neg_i  (neg1_r[g]),
      .mag_o  (mag3[g]),
      .half_o (half3[g]),
      .sqh_o  (sqh3[g]),
      .neg_o  (neg3[g])
    );
  end

  // Stages 4 and 5: terms, sums and saturation
  imot_combine #(.DATA_WIDTH(DATA_WIDTH)) u_combine (
    .clk     (clk),
    .en_term (en[3]),
    .en_sum  (en[4]),
    .ctrl    (ctrl_r[2]),
    .mag     (mag3),
    .half    (half3),
    .sqh     (sqh3),
    .neg     (neg3),
    .res     (res)
  );

  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = res;

endmodule

`default_nettype wire

### src/imot_checker.sv
`default_nettype none

module imot_checker #(
  parameter int DATA_WIDTH = imot_pkg::DATA_WIDTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_tvalid,
  input wire logic                    in_tready,
  input wire logic                    in_tuser,
  input wire logic                    out_tvalid,
  input wire logic                    out_tready,
  input wire logic [4*DATA_WIDTH-1:0] out_tdata
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A ready sink never back-pressures the source
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // With no stall an accepted transaction reaches the output; vector results carry w zero
  a_latency_vec_w: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready ##1 out_tready ##1 out_tready ##1 out_tready
    |=> out_tvalid && ($past(in_tuser, 5) || out_tdata[DATA_WIDTH-1:0] == '0))
    else $error("result late or vector w not zero");

endmodule

bind imu_mount_orientation_transform_top imot_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### dv/imu_mount_orientation_transform_top_tb.sv
`default_nettype none

module imu_mount_orientation_transform_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW          = imot_pkg::DATA_WIDTH_DEF;
  localparam int SETTLE      = 2 * imot_pkg::NUM_STAGES;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 13;

  localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONE_Q = DW'(1) << (DW - 2);

  localparam longint SAT_HI = (longint'(1) << (DW - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (DW - 1));
  localparam longint unsigned SQH_FRAC = 64'd3037000500;
  localparam longint unsigned SQH_BIAS = 64'h8000_0000;

  // Boat axis i reads sensor axis ROW_SRC[s][i]; ROW_FLIP[s][i] negates it
  localparam logic [0:23][0:2][1:0] ROW_SRC = {
    {2'd0, 2'd1, 2'd2}, {2'd1, 2'd0, 2'd2}, {2'd0, 2'd1, 2'd2}, {2'd1, 2'd0, 2'd2},
    {2'd0, 2'd1, 2'd2}, {2'd0, 2'd1, 2'd2}, {2'd0, 2'd2, 2'd1}, {2'd0, 2'd2, 2'd1},
    {2'd0, 2'd2, 2'd1}, {2'd0, 2'd2, 2'd1}, {2'd1, 2'd0, 2'd2}, {2'd1, 2'd0, 2'd2},
    {2'd1, 2'd2, 2'd0}, {2'd1, 2'd2, 2'd0}, {2'd1, 2'd2, 2'd0}, {2'd1, 2'd2, 2'd0},
    {2'd2, 2'd0, 2'd1}, {2'd2, 2'd0, 2'd1}, {2'd2, 2'd0, 2'd1}, {2'd2, 2'd0, 2'd1},
    {2'd2, 2'd1, 2'd0}, {2'd2, 2'd1, 2'd0}, {2'd2, 2'd1, 2'd0}, {2'd2, 2'd1, 2'd0}
  };

  localparam logic [0:23][0:2] ROW_FLIP = {
    3'b000, 3'b100, 3'b110, 3'b010,
    3'b101, 3'b011, 3'b111, 3'b100, 3'b010, 3'b001, 3'b111, 3'b001,
    3'b110, 3'b101, 3'b011, 3'b000, 3'b110, 3'b101, 3'b011, 3'b000,
    3'b111, 3'b100, 3'b010, 3'b001
  };

  // Component 0 is w in the lowest bits, then x, y, z
  typedef logic [3:0][DW-1:0] quad_t;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          cfg_wr_en   = 1'b0;
  logic [imot_pkg::ORIENT_W-1:0] cfg_wr_data = '0;
  logic                          in_tvalid   = 1'b0;
  logic                          in_tready;
  quad_t                         in_tdata    = '0;
  logic                          in_tuser    = imot_pkg::CMD_VECTOR;
  logic                          out_tvalid;
  logic                          out_tready  = 1'b0;
  quad_t                         out_tdata;

  // Mounting as seen by the predictor
  int         mount_slot;
  logic [1:0] conj_code [4];
  logic       conj_neg [4];

  quad_t boat_frame_q [$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    mismatches = 0;
  int    vector_count = 0;
  int    quat_count = 0;
  int    results_checked = 0;
  int    mount_writes = 0;
  int    quiet_cycles = 0;

  imu_mount_orientation_transform_top #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Derive the conjugated unit quaternion of the mounting rotation
  function automatic void load_mount(input logic [imot_pkg::ORIENT_W-1:0] value);
    int m [3][3];
    int num [4];
    int s;
    int tr;
    int d;
    int big;
    int sq4;
    s = (value < imot_pkg::ORIENT_W'(imot_pkg::NUM_SLOTS)) ? int'(value) : 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = (int'(ROW_SRC[s][i]) == j) ? (ROW_FLIP[s][i] ? -1 : 1) : 0;
      end
    end
    for (int k = 0; k < 4; k++) num[k] = 0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      big = 0; d = tr + 1;
      num[1] = m[2][1] - m[1][2]; num[2] = m[0][2] - m[2][0]; num[3] = m[1][0] - m[0][1];
    end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
      big = 1; d = 1 + m[0][0] - m[1][1] - m[2][2];
      num[0] = m[2][1] - m[1][2]; num[2] = m[0][1] + m[1][0]; num[3] = m[0][2] + m[2][0];
    end else if (m[1][1] > m[2][2]) begin
      big = 2; d = 1 + m[1][1] - m[0][0] - m[2][2];
      num[0] = m[0][2] - m[2][0]; num[1] = m[0][1] + m[1][0]; num[3] = m[1][2] + m[2][1];
    end else begin
      big = 3; d = 1 + m[2][2] - m[0][0] - m[1][1];
      num[0] = m[1][0] - m[0][1]; num[1] = m[0][2] + m[2][0]; num[2] = m[1][2] + m[2][1];
    end
    // Four times the squared component picks the coefficient
    for (int k = 0; k < 4; k++) begin
      if (k == big) begin
        sq4 = d;
        conj_neg[k] = 1'b0;
      end else begin
        sq4 = (num[k] * num[k]) / d;
        conj_neg[k] = (num[k] < 0);
      end
      case (sq4)
        4:       conj_code[k] = imot_pkg::COEF_ONE;
        2:       conj_code[k] = imot_pkg::COEF_SQH;
        1:       conj_code[k] = imot_pkg::COEF_HALF;
        default: conj_code[k] = imot_pkg::COEF_ZERO;
      endcase
      if (k != 0) conj_neg[k] = ~conj_neg[k];
    end
    mount_slot = s;
  endfunction

  function automatic logic [DW-1:0] clamp(input longint sum);
    if (sum > SAT_HI) return MAXP;
    if (sum < SAT_LO) return MINN;
    return sum[DW-1:0];
  endfunction

  // One input component times quaternion coefficient k, rounded on the magnitude
  function automatic longint scaled(input logic [DW-1:0] c, input int k);
    longint          v;
    longint unsigned mag;
    v = longint'($signed(c));
    mag = (v < 0) ? -v : v;
    case (conj_code[k])
      imot_pkg::COEF_ONE:  mag = mag;
      imot_pkg::COEF_HALF: mag = (mag + 1) >> 1;
      imot_pkg::COEF_SQH:  mag = (mag * SQH_FRAC + SQH_BIAS) >> 32;
      default:             mag = 0;
    endcase
    return ((v < 0) ^ conj_neg[k]) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic quad_t to_boat_frame(input logic cmd, input quad_t p);
    quad_t  r;
    longint v;
    r = '0;
    if (cmd == imot_pkg::CMD_VECTOR) begin
      for (int k = 0; k < 3; k++) begin
        v = longint'($signed(p[1 + ROW_SRC[mount_slot][k]]));
        r[k + 1] = clamp(ROW_FLIP[mount_slot][k] ? -v : v);
      end
    end else begin
      r[0] = clamp(scaled(p[0], 0) - scaled(p[1], 1) - scaled(p[2], 2) - scaled(p[3], 3));
      r[1] = clamp(scaled(p[0], 1) + scaled(p[1], 0) + scaled(p[2], 3) - scaled(p[3], 2));
      r[2] = clamp(scaled(p[0], 2) - scaled(p[1], 3) + scaled(p[2], 0) + scaled(p[3], 1));
      r[3] = clamp(scaled(p[0], 3) + scaled(p[1], 2) - scaled(p[2], 1) + scaled(p[3], 0));
    end
    return r;
  endfunction

  function automatic quad_t make_quad(input logic [DW-1:0] w, x, y, z);
    return {z, y, x, w};
  endfunction

  // Corner values, small values near zero and unit-scale components; half the picks full range
  function automatic logic [DW-1:0] pick_component();
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(5))
          0:       return MAXP;
          1:       return MINN;
          2:       return MINN + 1;
          3:       return '0;
          4:       return '1;
          default: return 1;
        endcase
      end
      1:       return DW'($urandom_range(15)) - 8;
      2:       return ($urandom_range(1) ? ONE_Q : -ONE_Q) + DW'($urandom_range(31)) - 16;
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Predict on input transactions, check output transactions, track register writes
  always @(posedge clk) begin
    quad_t want;
    quad_t got;
    if (!rst_n) begin
      load_mount('0);
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        results_checked++;
        if (boat_frame_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", got));
        end else begin
          want = boat_frame_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("result %0d field %s got %h want %h (slot %0d)",
                                        results_checked, (k == 0) ? "w" : (k == 1) ? "x" :
                                        (k == 2) ? "y" : "z", got[k], want[k], mount_slot));
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        boat_frame_q.push_back(to_boat_frame(in_tuser, in_tdata));
        if (in_tuser == imot_pkg::CMD_VECTOR) vector_count++;
        else quat_count++;
      end
      if (cfg_wr_en) begin
        load_mount(cfg_wr_data);
        mount_writes++;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] timeout: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
      $display("FAIL imu_mount_orientation_transform_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic cmd, input quad_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid, let every pending result come back, then let the pipe settle
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (boat_frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mount(input int value);
    drain_pipe();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= imot_pkg::ORIENT_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Forward mounting straight out of reset, no register write
  task automatic test_reset_orientation();
    send_sample(imot_pkg::CMD_VECTOR, make_quad(MAXP, MAXP, MINN, '1));
    send_sample(imot_pkg::CMD_QUAT, make_quad(ONE_Q, '0, '0, '0));
    send_sample(imot_pkg::CMD_QUAT, make_quad(MINN, MINN, MAXP, 1));
  endtask

  // Aft: negated axes saturate on the most negative input
  task automatic test_half_turn();
    set_mount(2);
    send_sample(imot_pkg::CMD_VECTOR, make_quad('0, MINN, MINN, MINN));
    send_sample(imot_pkg::CMD_QUAT, make_quad(MINN, MAXP, MINN, MAXP));
    send_sample(imot_pkg::CMD_VECTOR, make_quad(MAXP, MAXP, '1, 1));
  endtask

  // Starboard: sqrt(1/2) products, rounding and saturating sums
  task automatic test_quarter_turn();
    set_mount(1);
    send_sample(imot_pkg::CMD_QUAT, make_quad(MAXP, MAXP, MAXP, MAXP));
    send_sample(imot_pkg::CMD_QUAT, make_quad(1, '1, 3, -3));
    send_sample(imot_pkg::CMD_QUAT, make_quad(MINN, MINN, MINN, MINN));
    send_sample(imot_pkg::CMD_VECTOR, make_quad('0, MINN, MAXP, 5));
  endtask

  // Third-turn mounting: halving with ties away from zero
  task automatic test_third_turn();
    set_mount(12);
    send_sample(imot_pkg::CMD_QUAT, make_quad(1, 3, '1, -5));
    send_sample(imot_pkg::CMD_QUAT, make_quad(MAXP, MINN, MAXP, MINN));
    send_sample(imot_pkg::CMD_VECTOR, make_quad(MINN, 1, 2, 3));
  endtask

  // Last valid slot, then register values past the table act as forward
  task automatic test_edge_orientations();
    int settings [3];
    settings[0] = imot_pkg::NUM_SLOTS - 1;
    settings[1] = imot_pkg::NUM_SLOTS;
    settings[2] = (1 << imot_pkg::ORIENT_W) - 1;
    for (int i = 0; i < 3; i++) begin
      set_mount(settings[i]);
      send_sample(imot_pkg::CMD_VECTOR, make_quad(MAXP, MINN, 7, MAXP));
      send_sample(imot_pkg::CMD_QUAT, make_quad(ONE_Q, MINN, 3, MAXP));
    end
  endtask

  // Every register value once, in shuffled order, through all idling modes
  task automatic test_random_sweep();
    int order [1 << imot_pkg::ORIENT_W];
    int j;
    int tmp;
    quad_t v;
    for (int i = 0; i < (1 << imot_pkg::ORIENT_W); i++) order[i] = i;
    for (int i = (1 << imot_pkg::ORIENT_W) - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int ph = 0; ph < (1 << imot_pkg::ORIENT_W); ph++) begin
      set_mount(order[ph]);
      if (ph < 11) set_idling(25, 71);
      else if (ph < 22) set_idling(71, 25);
      else set_idling(0, 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        for (int k = 0; k < 4; k++) v[k] = pick_component();
        send_sample($urandom_range(1) ? imot_pkg::CMD_QUAT : imot_pkg::CMD_VECTOR, v);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(25, 71);
    test_reset_orientation();
    test_half_turn();
    test_quarter_turn();
    test_third_turn();
    test_edge_orientations();
    test_random_sweep();
    drain_pipe();
    $display("Checked %0d results: %0d vector and %0d quaternion transactions",
             results_checked, vector_count, quat_count);
    $display("Mount register written %0d times, all 32 values, under three idling modes",
             mount_writes);
    if (mismatches == 0) begin
      $display("PASS imu_mount_orientation_transform_top");
    end else begin
      $display("FAIL imu_mount_orientation_transform_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
